@@ src/sha1_pkg.sv @@
package sha1_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned Rounds     = 80;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;

  // classified command from front to back
  typedef enum logic [1:0] {
    CmdIdle = 2'd0,
    CmdByte = 2'd1,
    CmdEnd  = 2'd2,
    CmdBoth = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle  = 3'd0,
    StPad   = 3'd1,
    StRound = 3'd2,
    StFold  = 3'd3,
    StOut   = 3'd4
  } back_state_e;

  typedef struct packed {
    logic [31:0] h0;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] h4;
  } digest_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20) return K0;
    else if (t < 7'd40) return K1;
    else if (t < 7'd60) return K2;
    else return K3;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (t < 7'd20) return (b & c) | (~b & d);
    else if (t < 7'd40) return b ^ c ^ d;
    else if (t < 7'd60) return (b & c) | (b & d) | (c & d);
    else return b ^ c ^ d;
  endfunction

endpackage

@@ src/sha1_if.sv @@
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_of_message;
  modport source (output valid, data_byte, byte_present, last_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, last_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_h0;
  logic [31:0] digest_h1;
  logic [31:0] digest_h2;
  logic [31:0] digest_h3;
  logic [31:0] digest_h4;
  modport source (output valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                  input ready);
  modport sink   (input valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                  output ready);
endinterface

@@ src/sha1_front.sv @@
module sha1_front
  import sha1_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha1_in_if.sink     in_if,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          fifo_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          push, pop;
  cmd_t          cls;

  // idle beats are dropped here
  always_comb begin
    cls.data = in_if.data_byte;
    case ({in_if.last_of_message, in_if.byte_present})
      2'b01:   cls.cmd = CmdByte;
      2'b10:   cls.cmd = CmdEnd;
      2'b11:   cls.cmd = CmdBoth;
      default: cls.cmd = CmdIdle;
    endcase
  end

  assign in_if.ready = (cnt_q != (AW+1)'(Depth));
  assign push  = in_if.valid && in_if.ready && (cls.cmd != CmdIdle);
  assign pop   = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = fifo_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue overflow");
  a_no_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> cmd_o.cmd != CmdIdle) else $error("idle in queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif

endmodule

@@ src/sha1_core.sv @@
module sha1_core
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  sha1_out_if.source  out_if
);

  back_state_e   state_q, state_d;
  logic [31:0]   w_q [16];
  logic [31:0]   h_q [5];
  logic [31:0]   a_q, b_q, c_q, d_q, e_q;
  logic [5:0]    fill_q;
  logic [63:0]   len_q;
  logic [6:0]    t_q;
  logic          fin_q;   // message end pending (padding after this block)
  logic          lenblk_q; // current pad block carries the length
  logic          pad_q;   // 0x80 already placed in an earlier pad block
  digest_t       dig_q;
  logic          ovalid_q;

  logic          take;
  logic          has_byte, has_end;
  logic [3:0]    s;
  logic [31:0]   wx, wt, tmp;
  logic [63:0]   bits;

  assign take     = (state_q == StIdle) && cmd_valid_i;
  assign cmd_ready_o = (state_q == StIdle);
  assign has_byte = (cmd_i.cmd == CmdByte) || (cmd_i.cmd == CmdBoth);
  assign has_end  = (cmd_i.cmd == CmdEnd)  || (cmd_i.cmd == CmdBoth);
  assign bits     = {len_q[60:0], 3'b000};

  assign s  = t_q[3:0];
  assign wx = w_q[4'(s + 4'd13)] ^ w_q[4'(s + 4'd8)] ^ w_q[4'(s + 4'd2)] ^ w_q[s];
  assign wt = (t_q < 7'd16) ? w_q[s] : {wx[30:0], wx[31]};
  assign tmp = {a_q[26:0], a_q[31:27]} + round_f(t_q, b_q, c_q, d_q) + e_q
             + round_k(t_q) + wt;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (take) begin
          if (has_byte && fill_q == 6'd63) state_d = StRound;
          else if (has_end) state_d = StPad;
        end
      end
      StPad:   state_d = StRound;
      StRound: if (t_q == 7'(Rounds-1)) state_d = StFold;
      StFold: begin
        if (!fin_q) state_d = StIdle;
        else if (lenblk_q) state_d = StOut;
        else state_d = StPad;
      end
      StOut:   if (!ovalid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // payload datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        // bytes land big-endian straight in the schedule window
        if (take && has_byte) w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= cmd_i.data;
        if (take && has_byte && fill_q == 6'd63) begin
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
        end
      end
      StPad: begin
        // bytes below the fill count stay, the rest becomes padding
        for (int i = 0; i < 16; i++) begin
          for (int j = 0; j < 4; j++) begin
            if (lenblk_q && i >= 14)
              w_q[i][31-8*j -: 8] <= bits[63-8*((i-14)*4+j) -: 8];
            else if (6'(4*i+j) == fill_q && !pad_q)
              w_q[i][31-8*j -: 8] <= PadByte;
            else if (6'(4*i+j) >= fill_q)
              w_q[i][31-8*j -: 8] <= 8'h00;
          end
        end
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
      end
      StRound: begin
        if (t_q >= 7'd16) w_q[s] <= wt;
        e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]}; b_q <= a_q; a_q <= tmp;
      end
      StFold: begin
        dig_q.h0 <= h_q[0] + a_q;
        dig_q.h1 <= h_q[1] + b_q;
        dig_q.h2 <= h_q[2] + c_q;
        dig_q.h3 <= h_q[3] + d_q;
        dig_q.h4 <= h_q[4] + e_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      len_q    <= '0;
      t_q      <= '0;
      fin_q    <= 1'b0;
      lenblk_q <= 1'b0;
      pad_q    <= 1'b0;
      ovalid_q <= 1'b0;
      h_q[0] <= H0Init; h_q[1] <= H1Init; h_q[2] <= H2Init;
      h_q[3] <= H3Init; h_q[4] <= H4Init;
    end else begin
      state_q <= state_d;
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          t_q <= '0;
          if (take) begin
            fin_q <= has_end;
            if (has_byte) begin
              fill_q <= fill_q + 1'b1;
              len_q  <= len_q + 64'd1;
            end
            // pad block holds the length if 0x80 fits before it
            if (has_end)
              lenblk_q <= ((has_byte ? fill_q + 6'd1 : fill_q) < 6'(LenPos))
                          && !(has_byte && fill_q == 6'd63);
          end
        end
        StRound: t_q <= t_q + 1'b1;
        StFold: begin
          t_q <= '0;
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
          if (fin_q && lenblk_q) begin
            ovalid_q <= 1'b1;
          end else if (fin_q) begin
            // second pad block: 0x80 already placed or not, length follows
            lenblk_q <= 1'b1;
            if (fill_q == 6'd0) fill_q <= 6'd0;
          end
        end
        StPad: begin
          pad_q <= 1'b1;
          if (!lenblk_q) fill_q <= '0;
        end
        StOut: begin
          if (!ovalid_q) begin
            fill_q <= '0; len_q <= '0; fin_q <= 1'b0; lenblk_q <= 1'b0; pad_q <= 1'b0;
            h_q[0] <= H0Init; h_q[1] <= H1Init; h_q[2] <= H2Init;
            h_q[3] <= H3Init; h_q[4] <= H4Init;
          end
        end
        default: ;
      endcase
    end
  end

  // output drive
  always_comb begin
    out_if.valid     = ovalid_q;
    out_if.digest_h0 = dig_q.h0;
    out_if.digest_h1 = dig_q.h1;
    out_if.digest_h2 = dig_q.h2;
    out_if.digest_h3 = dig_q.h3;
    out_if.digest_h4 = dig_q.h4;
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == StOut) else $error("digest outside output state");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound && t_q == 7'(Rounds-1) |=> state_q == StFold)
    else $error("round count slip");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !cmd_ready_o) else $error("ready while busy");
`endif

endmodule

@@ src/sha1_hash_engine.sv @@
// sha-1 engine: byte beats in, one 160-bit digest beat per message out
// bytes are taken only while the back end is idle; a full block runs the rounds, then a fold
// message end adds one or two pad blocks, each compressed the same way, then the digest beat
// the back end takes no byte while it compresses a block, so input waits in the queue
// a 4-entry command queue decouples input from the compression back end
// rst_ni async active low: chain words to the init vector, counts and queue cleared
module sha1_hash_engine
  import sha1_pkg::*;
#(
  parameter int unsigned CmdDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    in_if,
  sha1_out_if.source out_if
);

  // front to back command link
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // front classifies beats and drops idle ones
  sha1_front #(.Depth(CmdDepth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back end buffers bytes, pads and compresses
  sha1_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_if      (out_if)
  );

endmodule

@@ test/sha1_hash_engine_checker.sv @@
module sha1_hash_engine_checker
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sha1_in_if          in_mon,
  sha1_out_if         out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned digests_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]     chain_q [5];
  logic [7:0]      blk_bytes [64];
  int unsigned     fill_q;
  logic [63:0]     msg_len_q;
  digest_t         digest_fifo [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    int s;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int t = 0; t < Rounds; t++) begin
      s = t & 15;
      if (t >= 16) w[s] = rol(w[(s+13)&15] ^ w[(s+8)&15] ^ w[(s+2)&15] ^ w[s], 1);
      if (t < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      tmp = rol(a, 5) + f + e + k + w[s];
      e = d; d = c; c = rol(b, 30); b = a; a = tmp;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic fresh_message();
    chain_q[0] = H0Init; chain_q[1] = H1Init; chain_q[2] = H2Init;
    chain_q[3] = H3Init; chain_q[4] = H4Init;
    fill_q = 0;
    msg_len_q = '0;
  endtask

  // one input beat into the predicted hash state
  task automatic absorb_beat(input logic [7:0] data, input logic present, input logic last);
    logic [63:0] bit_len;
    digest_t dg;
    if (present) begin
      blk_bytes[fill_q] = data;
      fill_q++;
      msg_len_q++;
      if (fill_q == BlockBytes) begin
        compress();
        fill_q = 0;
      end
    end
    if (last) begin
      bit_len = msg_len_q << 3;
      blk_bytes[fill_q] = PadByte;
      fill_q++;
      if (fill_q > LenPos) begin
        while (fill_q < BlockBytes) blk_bytes[fill_q++] = 8'h00;
        compress();
        fill_q = 0;
      end
      while (fill_q < LenPos) blk_bytes[fill_q++] = 8'h00;
      for (int i = 0; i < 8; i++) blk_bytes[LenPos+i] = bit_len[63-8*i -: 8];
      compress();
      dg = '{chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
      digest_fifo.push_back(dg);
      fresh_message();
    end
  endtask

  initial begin
    fresh_message();
    fail_cnt_o = 0;
    digests_o  = 0;
  end

  assign pending_o = digest_fifo.size();

  always @(posedge clk_i) begin
    digest_t exp_dg;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready)
        absorb_beat(in_mon.data_byte, in_mon.byte_present, in_mon.last_of_message);
      if (out_mon.valid && out_mon.ready) begin
        digests_o++;
        if (digest_fifo.size() == 0) begin
          $error("digest beat with no message ended");
          fail_cnt_o++;
        end else begin
          exp_dg = digest_fifo.pop_front();
          if (out_mon.digest_h0 !== exp_dg.h0) begin
            $error("digest_h0 exp %h got %h", exp_dg.h0, out_mon.digest_h0); fail_cnt_o++;
          end
          if (out_mon.digest_h1 !== exp_dg.h1) begin
            $error("digest_h1 exp %h got %h", exp_dg.h1, out_mon.digest_h1); fail_cnt_o++;
          end
          if (out_mon.digest_h2 !== exp_dg.h2) begin
            $error("digest_h2 exp %h got %h", exp_dg.h2, out_mon.digest_h2); fail_cnt_o++;
          end
          if (out_mon.digest_h3 !== exp_dg.h3) begin
            $error("digest_h3 exp %h got %h", exp_dg.h3, out_mon.digest_h3); fail_cnt_o++;
          end
          if (out_mon.digest_h4 !== exp_dg.h4) begin
            $error("digest_h4 exp %h got %h", exp_dg.h4, out_mon.digest_h4); fail_cnt_o++;
          end
        end
      end
    end
  end

endmodule

@@ test/sha1_hash_engine_tb.sv @@
module sha1_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned digests;
  int unsigned beats_sent;
  int unsigned msgs_sent;
  bit          no_idle;    // last stretch of the run runs flat out
  bit          hold_req;   // asks the digest side for one long hold-off

  sha1_in_if  in_if ();
  sha1_out_if out_if ();

  sha1_hash_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  sha1_hash_engine_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .digests_o  (digests)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #30ms;
    $display("** sha1_hash_engine: FAILED **");
    $finish;
  end

  // digest side: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        // long stall so the command queue fills and input backs up
        for (int i = 0; i < 600; i++) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 13);
        out_if.ready <= 1'b0;
        for (int i = 1; i < burst; i++) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // drive one beat, hold until taken, then maybe leave a gap
  task automatic send_beat(input logic [7:0] data, input logic present, input logic last);
    int gap;
    in_if.valid           <= 1'b1;
    in_if.data_byte       <= data;
    in_if.byte_present    <= present;
    in_if.last_of_message <= last;
    // ready is stable mid-cycle, so it tells whether the next edge takes the beat
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    beats_sent++;
    if (last) msgs_sent++;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // whole message of len bytes; the end is either on the last byte or a bare marker
  task automatic send_message(input int len, input bit bare_end, input bit fixed,
                              input logic [7:0] fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = fixed ? fill : 8'($urandom());
      // occasional idle beat in the middle of a message
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom()), 1'b0, 1'b0);
      send_beat(b, 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_beat(8'($urandom()), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    in_if.valid           = 1'b0;
    in_if.data_byte       = 8'h00;
    in_if.byte_present    = 1'b0;
    in_if.last_of_message = 1'b0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    beats_sent = 0;
    msgs_sent  = 0;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle beat, empty string, single extreme bytes, bare end after three bytes
    send_beat(8'hA5, 1'b0, 1'b0);
    send_message(0, 1'b1, 1'b1, 8'h00);
    send_message(1, 1'b0, 1'b1, 8'h00);
    send_message(1, 1'b0, 1'b1, 8'hFF);
    send_message(3, 1'b1, 1'b1, 8'h5A);
    send_message(0, 1'b1, 1'b1, 8'h00);

    // padding boundaries: one pad block vs two, exact block fill
    send_message(55, 1'b0, 1'b0, 8'h00);
    send_message(56, 1'b0, 1'b0, 8'h00);
    send_message(63, 1'b1, 1'b0, 8'h00);
    send_message(64, 1'b0, 1'b0, 8'h00);
    send_message(119, 1'b0, 1'b0, 8'h00);
    send_message(128, 1'b1, 1'b0, 8'h00);

    // random messages, mostly short, a few spanning several blocks
    while (beats_sent < 1800) begin
      if (msgs_sent == 20) hold_req = 1'b1;
      if (msgs_sent == 40) begin
        in_if.valid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      if (beats_sent > 1500) no_idle = 1'b1;
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(100, 200);
        1:       len = $urandom_range(52, 68);
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len, 1'($urandom_range(0, 1)), 1'b0, 8'h00);
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("covered %0d input beats in %0d messages, %0d digests checked",
             beats_sent, msgs_sent, digests);
    $display("short, empty, pad-boundary and multi-block messages with stalls on both sides");
    if (fail_cnt == 0 && pending == 0) begin
      $display("** sha1_hash_engine: PASSED **");
    end else begin
      $display("** sha1_hash_engine: FAILED **");
    end
    $finish;
  end

endmodule
